// ===== sv/ppfa_pkg.sv =====
// ppfa_pkg: shared types and constants for the ping-pong frame averager
// no dependencies; imported by ppfa_seq, ppfa_accum and the top level

package ppfa_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 24;
   localparam int CFG_W     = 4;
   localparam int FCNT_W    = 8;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;
   localparam logic [CFG_W-1:0] SHIFT_MIN = 4'd1;
   localparam logic [CFG_W-1:0] SHIFT_MAX = 4'd8;

   // per-item control that travels from the sequencer into the accumulate stage
   typedef struct packed {
      logic             act_is_a;  // bank a takes the sample
      logic             emit;      // idle bank is read out and cleared
      logic             last;      // final position of the frame
      logic             fresh;     // first frame of the period: active entry starts at zero
      logic [CFG_W-1:0] shift;     // effective frames_log2
   } item_ctl_type;

endpackage

// ===== sv/ping_pong_frame_averager_top.sv =====
// ping_pong_frame_averager_top: ping-pong frame averaging accumulator
// depends on ppfa_pkg, ppfa_ram, ppfa_seq, ppfa_accum
//
//   channel   ports                                   dir   role
//   req       req_valid req_ready req_sample          in    one sample per item
//   rsp       rsp_valid rsp_ready rsp_average rsp_last out  averaged idle-bank value
//   csr       csr_valid csr_ready csr_frames_log2     in    frames_log2 register write
//
// One item per cycle unless stalled; a result is registered in the accumulate stage, then
// in the result register. Each item does one read-modify-write per bank RAM: read at
// accept, write when the item leaves the accumulate stage. The bank RAMs need no clearing
// since the first frame of every period treats the active entry as zero.
// The input stalls only while a result is waiting and another readout is behind it.

module ping_pong_frame_averager_top
   import ppfa_pkg::*;
#(
   parameter int FRAME_LEN = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_frames_log2
);

   localparam int POS_W = $clog2(FRAME_LEN);

   logic             accept;
   logic [POS_W-1:0] pos;
   item_ctl_type     ctl;
   logic [SUM_W-1:0] rd_data_a, rd_data_b;
   logic             wr_en_a, wr_en_b;
   logic [POS_W-1:0] wr_addr;
   logic [SUM_W-1:0] wr_data_a, wr_data_b;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // position and bank control
   ppfa_seq #(
      .FRAME_LEN (FRAME_LEN),
      .POS_W     (POS_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_frames_log2 (csr_frames_log2),
      .accept          (accept),
      .pos             (pos),
      .ctl             (ctl)
   );

   // bank a sums
   ppfa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (FRAME_LEN)
   ) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data_a),
      .rd_en   (accept),
      .rd_addr (pos),
      .rd_data (rd_data_a)
   );

   // bank b sums
   ppfa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (FRAME_LEN)
   ) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data_b),
      .rd_en   (accept),
      .rd_addr (pos),
      .rd_data (rd_data_b)
   );

   // accumulate, read out and clear
   ppfa_accum #(
      .FRAME_LEN (FRAME_LEN),
      .POS_W     (POS_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pos         (pos),
      .ctl         (ctl),
      .sample      (req_sample),
      .take_ready  (req_ready),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .wr_en_a     (wr_en_a),
      .wr_en_b     (wr_en_b),
      .wr_addr     (wr_addr),
      .wr_data_a   (wr_data_a),
      .wr_data_b   (wr_data_b),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== sv/ppfa_ram.sv =====
// ppfa_ram: generic single-write, single-read synchronous RAM
// registered read data, holds while rd_en is low; no dependencies

module ppfa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ppfa_seq.sv =====
// ppfa_seq: position, frame count and bank selection for each accepted item
// depends on ppfa_pkg; also holds the frames_log2 register

module ppfa_seq
   import ppfa_pkg::*;
#(
   parameter int FRAME_LEN = 256,
   parameter int POS_W     = $clog2(FRAME_LEN)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [CFG_W-1:0] csr_frames_log2,
   input  logic             accept,
   output logic [POS_W-1:0] pos,
   output item_ctl_type     ctl
);

   logic [CFG_W-1:0]  frames_log2_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FCNT_W-1:0] frame_count_ff, frame_count_in;
   logic              active_is_a_ff, active_is_a_in;
   logic              first_period_ff, first_period_in;

   logic [CFG_W-1:0]  shift_eff;
   logic [FCNT_W:0]   period_limit;
   logic              is_last;
   logic              period_end;

   // clamp the shift into its legal range
   always_comb begin
      if (frames_log2_ff < SHIFT_MIN) begin
         shift_eff = SHIFT_MIN;
      end else if (frames_log2_ff > SHIFT_MAX) begin
         shift_eff = SHIFT_MAX;
      end else begin
         shift_eff = frames_log2_ff;
      end
   end

   assign period_limit = ((FCNT_W+1)'(1) << shift_eff) - (FCNT_W+1)'(1);
   assign is_last      = (pos_ff == POS_W'(FRAME_LEN - 1));
   assign period_end   = ({1'b0, frame_count_ff} >= period_limit);

   // control for the item at the head of the input
   always_comb begin
      ctl.act_is_a = active_is_a_ff;
      ctl.emit     = (frame_count_ff == '0) && !first_period_ff;
      ctl.last     = is_last;
      ctl.fresh    = (frame_count_ff == '0);
      ctl.shift    = shift_eff;
   end
   assign pos = pos_ff;

   // frame end bookkeeping and bank swap
   always_comb begin
      pos_in          = pos_ff;
      frame_count_in  = frame_count_ff;
      active_is_a_in  = active_is_a_ff;
      first_period_in = first_period_ff;
      if (accept) begin
         if (is_last) begin
            pos_in = '0;
            if (period_end) begin
               active_is_a_in  = !active_is_a_ff;
               frame_count_in  = '0;
               first_period_in = 1'b0;
            end else begin
               frame_count_in = frame_count_ff + FCNT_W'(1);
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_log2_ff  <= CFG_RESET;
         pos_ff          <= '0;
         frame_count_ff  <= '0;
         active_is_a_ff  <= 1'b1;
         first_period_ff <= 1'b1;
      end else begin
         if (csr_valid) begin
            frames_log2_ff <= csr_frames_log2;
         end
         pos_ff          <= pos_in;
         frame_count_ff  <= frame_count_in;
         active_is_a_ff  <= active_is_a_in;
         first_period_ff <= first_period_in;
      end
   end

   // position stays inside the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_LEN - 1))
      else $error("position past frame end");

   // the first period ends only at a frame end
   a_first_period_end: assert property (@(posedge clock) disable iff (reset)
      $fell(first_period_ff) |-> $past(pos_ff) == POS_W'(FRAME_LEN - 1))
      else $error("first period ended mid-frame");

endmodule

// ===== sv/ppfa_accum.sv =====
// ppfa_accum: read-modify-write stage and result register
// depends on ppfa_pkg; consumes the registered bank read data, which holds during a stall

module ppfa_accum
   import ppfa_pkg::*;
#(
   parameter int FRAME_LEN = 256,
   parameter int POS_W     = $clog2(FRAME_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [POS_W-1:0]           pos,
   input  item_ctl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic                       take_ready,
   input  logic [SUM_W-1:0]           rd_data_a,
   input  logic [SUM_W-1:0]           rd_data_b,
   output logic                       wr_en_a,
   output logic                       wr_en_b,
   output logic [POS_W-1:0]           wr_addr,
   output logic [SUM_W-1:0]           wr_data_a,
   output logic [SUM_W-1:0]           wr_data_b,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_last
);

   logic                       s1_valid_ff;
   item_ctl_type               s1_ctl_ff;
   logic [POS_W-1:0]           s1_pos_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff;
   logic                       rsp_last_ff;

   logic                       s1_fire;
   logic [SUM_W-1:0]           old_sum;
   logic signed [SUM_W-1:0]    idle_sum;
   logic signed [SUM_W-1:0]    idle_shifted;
   logic [SUM_W-1:0]           new_sum;

   // stage moves on unless its result has nowhere to go
   assign s1_fire    = s1_valid_ff && (!s1_ctl_ff.emit || !rsp_valid_ff || rsp_ready);
   assign take_ready = !s1_valid_ff || s1_fire;

   // accumulate into the active bank, first frame starts from zero
   assign old_sum  = s1_ctl_ff.act_is_a ? rd_data_a : rd_data_b;
   assign idle_sum = s1_ctl_ff.act_is_a ? rd_data_b : rd_data_a;
   assign new_sum  = (s1_ctl_ff.fresh ? '0 : old_sum)
                   + {{(SUM_W-SAMPLE_W){s1_sample_ff[SAMPLE_W-1]}}, s1_sample_ff};
   assign idle_shifted = idle_sum >>> s1_ctl_ff.shift;

   // active bank gets the new sum, idle bank is cleared when read out
   assign wr_addr   = s1_pos_ff;
   assign wr_en_a   = s1_fire && (s1_ctl_ff.act_is_a || s1_ctl_ff.emit);
   assign wr_en_b   = s1_fire && (!s1_ctl_ff.act_is_a || s1_ctl_ff.emit);
   assign wr_data_a = s1_ctl_ff.act_is_a ? new_sum : '0;
   assign wr_data_b = s1_ctl_ff.act_is_a ? '0 : new_sum;

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff    <= ctl;
         s1_pos_ff    <= pos;
         s1_sample_ff <= sample;
      end
      if (s1_fire && s1_ctl_ff.emit) begin
         rsp_average_ff <= idle_shifted[SAMPLE_W-1:0];
         rsp_last_ff    <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_last    = rsp_last_ff;

   // both banks are written only while reading out the idle bank
   a_dual_write: assert property (@(posedge clock) disable iff (reset)
      wr_en_a && wr_en_b |-> s1_ctl_ff.emit)
      else $error("both banks written without readout");

   // readout happens only in the first frame of a period
   a_emit_fresh: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ctl_ff.emit |-> s1_ctl_ff.fresh)
      else $error("readout outside first frame");

   // input stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !take_ready |-> s1_valid_ff && s1_ctl_ff.emit && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a held result");

endmodule
